@@ src/modbus_rtu_master_framer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Modbus RTU master framer assertion macros
// Shared property macros for the framer modules, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_MASTER_FRAMER_UNIT_ASSERT_SVH
`define MODBUS_RTU_MASTER_FRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define MRTU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrtu assertion failed");

// next-cycle implication
`define MRTU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrtu assertion failed");

`endif

@@ src/mrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// mrtu_pkg
// Codes, job format and CRC-16 helper shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mrtu_pkg;

	typedef enum logic [1:0] {
		OP_HEADER  = 2'd0,
		OP_WORD    = 2'd1,
		OP_RX_BYTE = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	localparam logic [1:0] FK_READ_HOLD    = 2'd0;
	localparam logic [1:0] FK_WRITE_MULTI  = 2'd1;
	localparam logic [1:0] FK_WRITE_SINGLE = 2'd2;
	localparam logic [1:0] FK_READ_INPUT   = 2'd3;

	localparam logic [1:0] RES_TX      = 2'd0;
	localparam logic [1:0] RES_REJECT  = 2'd1;
	localparam logic [1:0] RES_VERDICT = 2'd2;

	localparam logic [1:0] RJ_NONE    = 2'd0;
	localparam logic [1:0] RJ_ADDRESS = 2'd1;
	localparam logic [1:0] RJ_COUNT   = 2'd2;

	localparam logic [1:0] VD_OK       = 2'd0;
	localparam logic [1:0] VD_ADDRESS  = 2'd1;
	localparam logic [1:0] VD_FUNCTION = 2'd2;
	localparam logic [1:0] VD_CRC      = 2'd3;

	localparam logic CFG_MAX_SLAVE = 1'b0;
	localparam logic CFG_MAX_COUNT = 1'b1;

	localparam logic [7:0]  MAX_SLAVE_RESET = 8'd247;
	localparam logic [7:0]  MAX_COUNT_RESET = 8'd123;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		JOB_HEADER  = 2'd0,
		JOB_WORD    = 2'd1,
		JOB_REJECT  = 2'd2,
		JOB_VERDICT = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  slave;
		logic [1:0]  fkind;
		logic [15:0] a;
		logic [15:0] b;
		logic        crc_end;
		logic [1:0]  code;
	} job_t;

	function automatic logic [7:0] func_code(input logic [1:0] fk);
		logic [7:0] c;
		unique case (fk)
			FK_READ_HOLD:    c = 8'h03;
			FK_WRITE_MULTI:  c = 8'h10;
			FK_WRITE_SINGLE: c = 8'h06;
			default:         c = 8'h04;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/mrtu_queue.sv @@
// ----------------------------------------------------------------------------
// mrtu_queue
// Small job FIFO between the request classifier and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mrtu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mrtu_pkg::job_t push_job,
	input  wire logic          pop,
	output mrtu_pkg::job_t     head_job,
	output logic               full,
	output logic               empty
);
	import mrtu_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`include "modbus_rtu_master_framer_unit_assert.svh"
	`MRTU_ASSERT_NOW(a_no_push_full, full, !push || pop)
	`MRTU_ASSERT_NOW(a_no_pop_empty, empty, !pop)
	`MRTU_ASSERT_NEXT(a_count_grows, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

@@ src/mrtu_front.sv @@
// ----------------------------------------------------------------------------
// mrtu_front
// Accepts input items, checks requests, tracks receive state, queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module mrtu_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  slave_address,
	input  wire logic [1:0]  function_kind,
	input  wire logic [15:0] start_address,
	input  wire logic [15:0] count_or_value,
	input  wire logic [15:0] data_word,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        rx_last,
	input  wire logic        q_full,
	output logic             q_push,
	output mrtu_pkg::job_t   q_job
);
	import mrtu_pkg::*;

	typedef enum logic [1:0] {
		RXP_ADDR = 2'd0,
		RXP_FUNC = 2'd1,
		RXP_DATA = 2'd2
	} rx_pos_t;

	logic [7:0]  max_slave_q;
	logic [7:0]  max_count_q;
	logic [7:0]  cur_slave_q;
	logic [7:0]  last_fc_q;
	logic [7:0]  words_q;
	logic [15:0] rx_crc_q;
	rx_pos_t     rx_pos_q;
	logic [1:0]  rx_err_q;

	logic [7:0]  cur_slave_n;
	logic [7:0]  last_fc_n;
	logic [7:0]  words_n;
	logic [15:0] rx_crc_n;
	rx_pos_t     rx_pos_n;
	logic [1:0]  rx_err_n;
	logic        push_n;
	job_t        job_n;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && push_n;
	assign q_job    = job_n;

	always_comb begin
		cur_slave_n   = cur_slave_q;
		last_fc_n     = last_fc_q;
		words_n       = words_q;
		rx_crc_n      = rx_crc_q;
		rx_pos_n      = rx_pos_q;
		rx_err_n      = rx_err_q;
		push_n        = 1'b0;
		job_n         = '0;
		job_n.slave   = slave_address;
		job_n.fkind   = function_kind;
		job_n.a       = start_address;
		job_n.b       = count_or_value;
		unique case (op_t'(operation))
			OP_HEADER: begin
				words_n     = '0;
				cur_slave_n = slave_address;
				push_n      = 1'b1;
				priority if (slave_address > max_slave_q) begin
					job_n.kind = JOB_REJECT;
					job_n.code = RJ_ADDRESS;
				end else if (function_kind != FK_WRITE_SINGLE &&
						count_or_value > {8'h00, max_count_q}) begin
					job_n.kind = JOB_REJECT;
					job_n.code = RJ_COUNT;
				end else begin
					job_n.kind    = JOB_HEADER;
					last_fc_n     = func_code(function_kind);
					job_n.crc_end = (function_kind != FK_WRITE_MULTI) ||
						(count_or_value[7:0] == 8'h00);
					if (function_kind == FK_WRITE_MULTI) begin
						words_n = count_or_value[7:0];
					end
				end
			end
			OP_WORD: begin
				if (words_q != '0) begin
					push_n        = 1'b1;
					job_n.kind    = JOB_WORD;
					job_n.a       = data_word;
					job_n.crc_end = (words_q == 8'd1);
					words_n       = words_q - 1'b1;
				end
			end
			OP_RX_BYTE: begin
				rx_crc_n = crc_update(rx_crc_q, rx_byte);
				unique case (rx_pos_q)
					RXP_ADDR: begin
						if (rx_byte != cur_slave_q && rx_byte != 8'h00) begin
							rx_err_n = VD_ADDRESS;
						end
						rx_pos_n = RXP_FUNC;
					end
					RXP_FUNC: begin
						if (rx_err_q == VD_OK && rx_byte != last_fc_q) begin
							rx_err_n = VD_FUNCTION;
						end
						rx_pos_n = RXP_DATA;
					end
					default: begin
					end
				endcase
				if (rx_last) begin
					push_n     = 1'b1;
					job_n.kind = JOB_VERDICT;
					priority if (rx_err_n != VD_OK) begin
						job_n.code = rx_err_n;
					end else if (rx_pos_n != RXP_DATA) begin
						job_n.code = VD_FUNCTION;
					end else if (rx_crc_n == 16'h0000) begin
						job_n.code = VD_OK;
					end else begin
						job_n.code = VD_CRC;
					end
					rx_crc_n = CRC_INIT;
					rx_pos_n = RXP_ADDR;
					rx_err_n = VD_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slave_q <= MAX_SLAVE_RESET;
			max_count_q <= MAX_COUNT_RESET;
			cur_slave_q <= '0;
			last_fc_q   <= '0;
			words_q     <= '0;
			rx_crc_q    <= CRC_INIT;
			rx_pos_q    <= RXP_ADDR;
			rx_err_q    <= VD_OK;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_SLAVE: max_slave_q <= cfg_data;
					default:       max_count_q <= cfg_data;
				endcase
			end
			if (accept) begin
				cur_slave_q <= cur_slave_n;
				last_fc_q   <= last_fc_n;
				words_q     <= words_n;
				rx_crc_q    <= rx_crc_n;
				rx_pos_q    <= rx_pos_n;
				rx_err_q    <= rx_err_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/mrtu_back.sv @@
// ----------------------------------------------------------------------------
// mrtu_back
// Expands queued jobs into result items, one per cycle while out_ready allows, with the transmit CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module mrtu_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire mrtu_pkg::job_t q_job,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       tx_byte,
	output logic             tx_last,
	output logic [1:0]       reject_reason,
	output logic [1:0]       verdict
);
	import mrtu_pkg::*;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [1:0]  reason_q;
	logic [1:0]  verdict_q;
	logic [15:0] crc_q;
	logic [3:0]  idx_q;

	logic        load;
	logic        step;
	logic        done;
	logic [15:0] crc_base;
	logic [15:0] crc_n;
	logic [3:0]  n_data;
	logic [7:0]  data_b;
	logic [1:0]  kind_n;
	logic [7:0]  byte_n;
	logic        last_n;
	logic [1:0]  reason_n;
	logic [1:0]  verdict_n;

	assign load  = !out_valid_q || out_ready;
	assign step  = load && !q_empty;
	assign q_pop = step && done;

	always_comb begin
		crc_base = (q_job.kind == JOB_HEADER && idx_q == '0) ? CRC_INIT : crc_q;
		if (q_job.kind == JOB_HEADER) begin
			n_data = (q_job.fkind == FK_WRITE_MULTI) ? 4'd7 : 4'd6;
			unique case (idx_q[2:0])
				3'd0:    data_b = q_job.slave;
				3'd1:    data_b = func_code(q_job.fkind);
				3'd2:    data_b = q_job.a[15:8];
				3'd3:    data_b = q_job.a[7:0];
				3'd4:    data_b = q_job.b[15:8];
				3'd5:    data_b = q_job.b[7:0];
				default: data_b = {q_job.b[6:0], 1'b0};
			endcase
		end else begin
			n_data = 4'd2;
			data_b = idx_q[0] ? q_job.a[7:0] : q_job.a[15:8];
		end
	end

	always_comb begin
		crc_n     = crc_q;
		kind_n    = RES_TX;
		byte_n    = '0;
		last_n    = 1'b0;
		reason_n  = RJ_NONE;
		verdict_n = VD_OK;
		done      = 1'b1;
		unique case (q_job.kind)
			JOB_REJECT: begin
				kind_n   = RES_REJECT;
				reason_n = q_job.code;
			end
			JOB_VERDICT: begin
				kind_n    = RES_VERDICT;
				verdict_n = q_job.code;
			end
			default: begin
				priority if (idx_q < n_data) begin
					byte_n = data_b;
					crc_n  = crc_update(crc_base, data_b);
					done   = (idx_q == n_data - 4'd1) && !q_job.crc_end;
				end else if (idx_q == n_data) begin
					byte_n = crc_base[7:0];
					done   = 1'b0;
				end else begin
					byte_n = crc_base[15:8];
					last_n = 1'b1;
					crc_n  = CRC_INIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (step) begin
			kind_q    <= kind_n;
			byte_q    <= byte_n;
			last_q    <= last_n;
			reason_q  <= reason_n;
			verdict_q <= verdict_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			crc_q       <= CRC_INIT;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= !q_empty;
			end
			if (step) begin
				crc_q <= crc_n;
				idx_q <= done ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign tx_byte       = byte_q;
	assign tx_last       = last_q;
	assign reject_reason = reason_q;
	assign verdict       = verdict_q;

`include "modbus_rtu_master_framer_unit_assert.svh"
	`MRTU_ASSERT_NOW(a_last_is_tx, out_valid_q && last_q, kind_q == RES_TX)
	`MRTU_ASSERT_NOW(a_idx_bound, 1'b1, idx_q <= 4'd8)
	`MRTU_ASSERT_NEXT(a_pop_gives_out, q_pop, out_valid_q)

endmodule

`default_nettype wire

@@ src/modbus_rtu_master_framer_unit.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_master_framer_unit
// Modbus RTU master request framer with CRC-16 and response checker.
// ----------------------------------------------------------------------------
// An input item is taken whenever the four-entry job queue has room, and
// each result item is produced by the output sequencer while out_ready is
// high. A header yields up to nine results, a register word two or four, a
// rejection or a verdict one; the sequencer's one result per cycle sets the
// sustained rate, and the queue lets input keep flowing while a frame
// drains. The transmit CRC is computed in the sequencer, the receive CRC in
// the input stage.
`default_nettype none

module modbus_rtu_master_framer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  slave_address,
	input  wire logic [1:0]  function_kind,
	input  wire logic [15:0] start_address,
	input  wire logic [15:0] count_or_value,
	input  wire logic [15:0] data_word,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        rx_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       tx_byte,
	output logic             tx_last,
	output logic [1:0]       reject_reason,
	output logic [1:0]       verdict
);
	import mrtu_pkg::*;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	job_t push_job;
	job_t head_job;

	mrtu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.slave_address  (slave_address),
		.function_kind  (function_kind),
		.start_address  (start_address),
		.count_or_value (count_or_value),
		.data_word      (data_word),
		.rx_byte        (rx_byte),
		.rx_last        (rx_last),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_job          (push_job)
	);

	mrtu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	mrtu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (head_job),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.tx_byte       (tx_byte),
		.tx_last       (tx_last),
		.reject_reason (reject_reason),
		.verdict       (verdict)
	);

endmodule

`default_nettype wire
